>>> hdl/length_prefixed_frame_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
// Included by lpfd_parser.sv and length_prefixed_frame_deframer.sv; no other dependencies.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define LPFD_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`define LPFD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define LPFD_ASSERT_IMP(label, pre, post, msg)
`define LPFD_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

>>> hdl/lpfd_pkg.sv
// Shared types and constants of the length-prefixed frame deframer.
// Used by lpfd_parser and length_prefixed_frame_deframer; depends on nothing.
package lpfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 32;
    localparam int KIND_W     = 2;
    localparam int CODE_W     = 3;
    localparam int HDR_IDX_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 3;

    localparam logic [3:0][BYTE_W-1:0] MAGIC = {8'h50, 8'h43, 8'h54, 8'h53};
    localparam logic [BYTE_W-1:0] ENVELOPE_VERSION = 8'd1;

    localparam logic [HDR_IDX_W-1:0] HDR_VERSION  = 4'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_CHANNEL  = 4'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN0     = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN1     = 4'd7;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN2     = 4'd8;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN3     = 4'd9;

    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    localparam logic [CODE_W-1:0] ERR_MAGIC     = 3'd0;
    localparam logic [CODE_W-1:0] ERR_VERSION   = 3'd1;
    localparam logic [CODE_W-1:0] ERR_CHANNEL   = 3'd2;
    localparam logic [CODE_W-1:0] ERR_TOO_LARGE = 3'd3;
    localparam logic [CODE_W-1:0] ERR_ZERO_MAX  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELIABLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNRELIABLE  = 2'd2;

    localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD = 32'd65536;
    localparam logic [BYTE_W-1:0] RST_RELIABLE    = 8'd0;
    localparam logic [BYTE_W-1:0] RST_UNRELIABLE  = 8'd1;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_HALT    = 3'b100
    } t_phase;

    typedef struct packed {
        logic [LEN_W-1:0]  max_payload;
        logic [BYTE_W-1:0] reliable_code;
        logic [BYTE_W-1:0] unreliable_code;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              chan;
        logic              last;
        logic [CODE_W-1:0] code;
    } t_result;

endpackage

>>> hdl/lpfd_parser.sv
// Frame state and per-byte header/payload checks of the deframer.
// Depends on lpfd_pkg and length_prefixed_frame_deframer_defines.svh.
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [lpfd_pkg::BYTE_W-1:0]  i_byte,
    input  lpfd_pkg::t_cfg               i_cfg,
    output logic                         o_res_valid,
    output lpfd_pkg::t_result            o_res
);

    lpfd_pkg::t_phase                    r_phase, n_phase;
    logic [lpfd_pkg::HDR_IDX_W-1:0]      r_hdr_idx, n_hdr_idx;
    logic [lpfd_pkg::LEN_W-1:0]          r_count, n_count;
    logic                                r_chan, n_chan;
    logic [lpfd_pkg::LEN_W-1:0]          full_len;
    logic                                res_valid;
    lpfd_pkg::t_result                   res;

    assign full_len = {i_byte, r_count[23:0]};

    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_count   = r_count;
        n_chan    = r_chan;
        res_valid = 1'b0;
        res       = '0;
        if (i_step && r_phase != lpfd_pkg::PH_HALT) begin
            if (i_cfg.max_payload == '0) begin
                res_valid = 1'b1;
                res.kind  = lpfd_pkg::KIND_ERROR;
                res.code  = lpfd_pkg::ERR_ZERO_MAX;
                n_phase   = lpfd_pkg::PH_HALT;
            end else begin
                case (r_phase)
                    lpfd_pkg::PH_PAYLOAD: begin
                        res_valid = 1'b1;
                        res.kind  = lpfd_pkg::KIND_DATA;
                        res.data  = i_byte;
                        res.chan  = r_chan;
                        res.last  = (r_count <= lpfd_pkg::LEN_W'(1));
                        if (res.last) begin
                            n_phase   = lpfd_pkg::PH_HEADER;
                            n_hdr_idx = '0;
                            n_count   = '0;
                        end else begin
                            n_count = r_count - lpfd_pkg::LEN_W'(1);
                        end
                    end
                    lpfd_pkg::PH_HEADER: begin
                        n_hdr_idx = r_hdr_idx + lpfd_pkg::HDR_IDX_W'(1);
                        if (r_hdr_idx < lpfd_pkg::HDR_VERSION) begin
                            if (i_byte != lpfd_pkg::MAGIC[r_hdr_idx[1:0]]) begin
                                res_valid = 1'b1;
                                res.kind  = lpfd_pkg::KIND_ERROR;
                                res.code  = lpfd_pkg::ERR_MAGIC;
                                n_phase   = lpfd_pkg::PH_HALT;
                            end
                        end else begin
                            case (r_hdr_idx)
                                lpfd_pkg::HDR_VERSION: begin
                                    if (i_byte != lpfd_pkg::ENVELOPE_VERSION) begin
                                        res_valid = 1'b1;
                                        res.kind  = lpfd_pkg::KIND_ERROR;
                                        res.code  = lpfd_pkg::ERR_VERSION;
                                        n_phase   = lpfd_pkg::PH_HALT;
                                    end
                                end
                                lpfd_pkg::HDR_CHANNEL: begin
                                    if (i_byte == i_cfg.reliable_code) begin
                                        n_chan = 1'b0;
                                    end else if (i_byte == i_cfg.unreliable_code) begin
                                        n_chan = 1'b1;
                                    end else begin
                                        res_valid = 1'b1;
                                        res.kind  = lpfd_pkg::KIND_ERROR;
                                        res.code  = lpfd_pkg::ERR_CHANNEL;
                                        n_phase   = lpfd_pkg::PH_HALT;
                                    end
                                end
                                lpfd_pkg::HDR_LEN0: begin
                                    n_count = lpfd_pkg::LEN_W'(i_byte);
                                end
                                lpfd_pkg::HDR_LEN1: begin
                                    n_count[15:8] = i_byte;
                                end
                                lpfd_pkg::HDR_LEN2: begin
                                    n_count[23:16] = i_byte;
                                end
                                lpfd_pkg::HDR_LEN3: begin
                                    n_count   = full_len;
                                    n_hdr_idx = '0;
                                    if (full_len > i_cfg.max_payload) begin
                                        res_valid = 1'b1;
                                        res.kind  = lpfd_pkg::KIND_ERROR;
                                        res.code  = lpfd_pkg::ERR_TOO_LARGE;
                                        n_phase   = lpfd_pkg::PH_HALT;
                                    end else if (full_len == '0) begin
                                        res_valid = 1'b1;
                                        res.kind  = lpfd_pkg::KIND_EMPTY;
                                        res.chan  = r_chan;
                                        res.last  = 1'b1;
                                    end else begin
                                        n_phase = lpfd_pkg::PH_PAYLOAD;
                                    end
                                end
                                default: begin
                                    n_hdr_idx = '0;
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_phase   = lpfd_pkg::PH_HEADER;
                        n_hdr_idx = '0;
                        n_count   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lpfd_pkg::PH_HEADER;
            r_hdr_idx <= '0;
            r_count   <= '0;
            r_chan    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_count   <= n_count;
            r_chan    <= n_chan;
        end
    end

    assign o_res_valid = res_valid;
    assign o_res       = res;

    `LPFD_ASSERT_NEXT(a_halt_sticky, r_phase == lpfd_pkg::PH_HALT, r_phase == lpfd_pkg::PH_HALT, "halt left without reset")
    `LPFD_ASSERT_NEXT(a_error_halts, res_valid && res.kind == lpfd_pkg::KIND_ERROR, r_phase == lpfd_pkg::PH_HALT, "error did not halt")
    `LPFD_ASSERT_IMP(a_payload_count, r_phase == lpfd_pkg::PH_PAYLOAD, r_count != '0, "payload phase with zero count")

endmodule

>>> hdl/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer: input stage, config registers, result stage.
// Depends on lpfd_pkg, lpfd_parser and length_prefixed_frame_deframer_defines.svh.
//
//   Channel   Direction  Payload                                        Handshake
//   s_axis    in         tdata[7:0] rx_byte                             tvalid/tready
//   m_axis    out        tdata, tuser, tlast (see port list)            tvalid/tready
//   cfg       in         index, wdata                                   i_cfg_wr_en only
//
// One byte is accepted per clock unless a stalled result holds a full input stage.
// A byte sits in the input stage, is checked in one pass and its result is registered.
// While a result waits, one more byte can enter an empty input stage, then input stalls.
// Reset is synchronous and active low; no clearing pass is needed.
// After an error every byte is still accepted and dropped until reset.
`include "length_prefixed_frame_deframer_defines.svh"

module length_prefixed_frame_deframer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lpfd_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lpfd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [7:0] data_byte, [10:8] error_code
    output logic [lpfd_pkg::OUT_USER_W-1:0]  m_axis_tuser,   // [1:0] out_kind, [2] channel_id
    output logic                             m_axis_tlast,   // last_of_packet
    input  logic                             i_cfg_wr_en,
    input  logic [lpfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpfd_pkg::LEN_W-1:0]       i_cfg_wdata
);

    logic                            r_in_valid, n_in_valid;
    logic [lpfd_pkg::BYTE_W-1:0]     r_in_byte, n_in_byte;
    logic                            r_out_valid, n_out_valid;
    lpfd_pkg::t_result               r_out, n_out;
    lpfd_pkg::t_cfg                  r_cfg, n_cfg;
    logic                            advance;
    logic                            step;
    logic                            in_accept;
    logic                            res_valid;
    lpfd_pkg::t_result               res;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    lpfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_byte   = r_in_byte;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_cfg       = r_cfg;
        if (in_accept) begin
            n_in_valid = 1'b1;
            n_in_byte  = s_axis_tdata;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
        if (advance) begin
            n_out_valid = step && res_valid;
            n_out       = res;
        end
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lpfd_pkg::CFG_MAX_PAYLOAD: n_cfg.max_payload     = i_cfg_wdata;
                lpfd_pkg::CFG_RELIABLE:    n_cfg.reliable_code   = i_cfg_wdata[7:0];
                lpfd_pkg::CFG_UNRELIABLE:  n_cfg.unreliable_code = i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte <= n_in_byte;
        r_out     <= n_out;
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_cfg.max_payload     <= lpfd_pkg::RST_MAX_PAYLOAD;
            r_cfg.reliable_code   <= lpfd_pkg::RST_RELIABLE;
            r_cfg.unreliable_code <= lpfd_pkg::RST_UNRELIABLE;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.code, r_out.data};
    assign m_axis_tuser  = {r_out.chan, r_out.kind};
    assign m_axis_tlast  = r_out.last;

    `LPFD_ASSERT_NEXT(a_out_hold, r_out_valid && !m_axis_tready, r_out_valid && $stable(r_out), "stalled result changed")
    `LPFD_ASSERT_NEXT(a_in_hold, r_in_valid && !advance, r_in_valid && $stable(r_in_byte), "stalled byte lost")
    `LPFD_ASSERT_IMP(a_error_fields, r_out_valid && r_out.kind == lpfd_pkg::KIND_ERROR, !r_out.last && r_out.data == '0 && r_out.code <= lpfd_pkg::ERR_ZERO_MAX, "malformed error result")

endmodule
